// File: design/mpbe_pkg.sv
`timescale 1ns / 1ps

package mpbe_pkg;

    // register file layout
    localparam int NUM_PAIRS  = 4;
    localparam int CFG_REGS   = 2 * NUM_PAIRS;
    localparam int CFG_IDX_W  = 4;
    localparam int PAIR_W     = 2;
    localparam int LEN_W      = 3;
    localparam int PAT_W      = 35;
    localparam int REP_W      = 59;
    localparam int CFG_DATA_W = REP_W;
    localparam int REP_DATA_W = REP_W - LEN_W;

    // input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_end;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       chunk_done;
        logic       run_last;
    } t_out;

endpackage

// File: design/multi_pattern_byte_escaper_top.sv
`timescale 1ns / 1ps

// Byte escaper with a small lookahead window and four pattern/replacement pairs.
// A byte that neither fills the window nor ends its chunk is taken and yields
// nothing. Each head step goes through a sequencer that compares one pattern a
// cycle against the window head (up to NUM_PATTERNS patterns), emits one
// replacement byte a cycle while the output is not stalled (0..REPLACEMENT_BYTES
// bytes, one for a literal byte), then shifts the window; after the last step a
// closing state ends the transaction. A byte that fills the window costs one
// head step; a chunk-end byte costs at most one head step per pending byte, up to
// PATTERN_BYTES of them. The input is not ready during that time, and the sequencer
// waits on output back-pressure. The last result of every input transaction carries
// run_last; a chunk end that yields no byte gives one bare marker with byte_valid low.
module multi_pattern_byte_escaper_top
    import mpbe_pkg::*;
#(
    parameter int NUM_PATTERNS      = 4,
    parameter int PATTERN_BYTES     = 4,
    parameter int REPLACEMENT_BYTES = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int                FW      = $clog2(PATTERN_BYTES + 1);
    localparam int                WIN_W   = 8 * PATTERN_BYTES;
    localparam logic [LEN_W-1:0]  PB_LEN  = LEN_W'(PATTERN_BYTES);
    localparam logic [LEN_W-1:0]  RB_LEN  = LEN_W'(REPLACEMENT_BYTES);
    localparam logic [PAIR_W-1:0] LAST_K  = PAIR_W'(NUM_PATTERNS - 1);
    localparam logic [FW-1:0]     FULL_M1 = FW'(PATTERN_BYTES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_DROP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [PAIR_W-1:0]     r_k, n_k;
    logic                  r_end, n_end;
    logic [FW-1:0]         r_fill, n_fill;
    logic [WIN_W-1:0]      r_win, n_win;
    logic [REP_DATA_W-1:0] r_rep, n_rep;
    logic [LEN_W-1:0]      r_rlen, n_rlen;
    logic [LEN_W-1:0]      r_ridx, n_ridx;
    logic [LEN_W-1:0]      r_plen, n_plen;
    logic [7:0]            r_hold, n_hold;
    logic                  r_hold_v, n_hold_v;
    t_out                  r_out;
    logic                  r_ovalid;

    logic [PAT_W-1:0] r_pat  [NUM_PAIRS];
    logic [REP_W-1:0] r_repl [NUM_PAIRS];

    logic             in_acc;
    logic             out_free;
    logic             push;
    t_out             push_data;
    logic [PAT_W-1:0] cur_pat;
    logic [REP_W-1:0] cur_rep;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen_sat;
    logic             hit;
    logic [7:0]       emit_byte;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAIRS; p++) begin
                r_pat[p]  <= '0;
                r_repl[p] <= '0;
            end
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(CFG_REGS)) begin
            if (i_cfg_index[0]) begin
                r_repl[i_cfg_index[PAIR_W:1]] <= i_cfg_data[REP_W-1:0];
            end else begin
                r_pat[i_cfg_index[PAIR_W:1]] <= i_cfg_data[PAT_W-1:0];
            end
        end
    end

    // shared compare unit: one pattern against the window head
    assign cur_pat = r_pat[r_k];
    assign cur_rep = r_repl[r_k];
    assign plen    = cur_pat[LEN_W-1:0];

    always_comb begin
        hit = (plen != '0) && (plen <= PB_LEN) && ({{(8-LEN_W){1'b0}}, plen} <= 8'(r_fill));
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if (LEN_W'(i) < plen && cur_pat[LEN_W + 8*i +: 8] != r_win[8*i +: 8]) begin
                hit = 1'b0;
            end
        end
        rlen_sat = (cur_rep[LEN_W-1:0] > RB_LEN) ? RB_LEN : cur_rep[LEN_W-1:0];
    end

    assign emit_byte = r_rep[{r_ridx, 3'b000} +: 8];

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_end     = r_end;
        n_fill    = r_fill;
        n_win     = r_win;
        n_rep     = r_rep;
        n_rlen    = r_rlen;
        n_ridx    = r_ridx;
        n_plen    = r_plen;
        n_hold    = r_hold;
        n_hold_v  = r_hold_v;
        push      = 1'b0;
        push_data = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < PATTERN_BYTES; i++) begin
                        if (FW'(i) == r_fill) begin
                            n_win[8*i +: 8] = i_in_data.in_byte;
                        end
                    end
                    n_fill = r_fill + FW'(1);
                    n_end  = i_in_data.chunk_end;
                    if (i_in_data.chunk_end || r_fill == FULL_M1) begin
                        n_state = S_SCAN;
                        n_k     = '0;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_rep   = cur_rep[REP_W-1:LEN_W];
                    n_rlen  = rlen_sat;
                    n_plen  = plen;
                    n_ridx  = '0;
                    n_state = (rlen_sat == '0) ? S_DROP : S_EMIT;
                end else if (r_k == LAST_K) begin
                    // no pattern: head byte passes as a literal
                    n_rep   = REP_DATA_W'(r_win[7:0]);
                    n_rlen  = LEN_W'(1);
                    n_plen  = LEN_W'(1);
                    n_ridx  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + PAIR_W'(1);
                end
            end
            S_EMIT: begin
                // previous byte leaves the hold stage once a newer one exists
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        push      = 1'b1;
                        push_data = '{out_byte: r_hold, byte_valid: 1'b1,
                                      chunk_done: 1'b0, run_last: 1'b0};
                    end
                    n_hold   = emit_byte;
                    n_hold_v = 1'b1;
                    n_ridx   = r_ridx + LEN_W'(1);
                    if (r_ridx == r_rlen - LEN_W'(1)) begin
                        n_state = S_DROP;
                    end
                end
            end
            S_DROP: begin
                n_win  = r_win >> {r_plen, 3'b000};
                n_fill = r_fill - FW'(r_plen);
                if (r_end && n_fill != '0) begin
                    n_state = S_SCAN;
                    n_k     = '0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_hold_v) begin
                    if (out_free) begin
                        push      = 1'b1;
                        push_data = '{out_byte: r_hold, byte_valid: 1'b1,
                                      chunk_done: r_end, run_last: 1'b1};
                        n_hold_v  = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else if (r_end) begin
                    // chunk closed without any byte: bare marker
                    if (out_free) begin
                        push      = 1'b1;
                        push_data = '{out_byte: 8'h00, byte_valid: 1'b0,
                                      chunk_done: 1'b1, run_last: 1'b1};
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_hold_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_hold_v <= n_hold_v;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_end  <= n_end;
        r_win  <= n_win;
        r_rep  <= n_rep;
        r_rlen <= n_rlen;
        r_ridx <= n_ridx;
        r_plen <= n_plen;
        r_hold <= n_hold;
        if (push) begin
            r_out <= push_data;
        end
    end

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(PATTERN_BYTES))
        else $error("window fill above depth");

    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < FW'(PATTERN_BYTES) && !r_hold_v))
        else $error("idle with full window or pending byte");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |->
            (o_out_data.chunk_done && o_out_data.run_last && o_out_data.out_byte == 8'h00))
        else $error("malformed chunk-end marker");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.chunk_done) |-> o_out_data.run_last)
        else $error("chunk done without run last");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import mpbe_pkg::*;
();
    // register map: pattern k at 2k, replacement k at 2k+1
    localparam int PAT_REG_BASE = 0;
    localparam int REP_REG_BASE = 1;
    localparam int REG_STRIDE   = 2;

    // escaped stream predictor and store of pending output transactions
    class escaper_scoreboard;
        localparam int WINDOW_BYTES    = 4;
        localparam int MAX_PATTERNS    = 4;
        localparam int MAX_REPLACEMENT = 7;

        logic [PAT_W-1:0] pat_reg [NUM_PAIRS];
        logic [REP_W-1:0] rep_reg [NUM_PAIRS];
        logic [7:0]       window [WINDOW_BYTES];
        int               fill;
        logic [7:0]       emitted [$];
        t_out             expected_q [$];
        int               mismatches;

        function void clear();
            foreach (pat_reg[k]) begin
                pat_reg[k] = '0;
                rep_reg[k] = '0;
            end
            foreach (window[i]) window[i] = '0;
            fill = 0;
            mismatches = 0;
            expected_q.delete();
        endfunction

        // out-of-range indexes are dropped, pattern writes keep their low bits only
        function void store_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (int'(index) >= CFG_REGS) return;
            if (int'(index) % REG_STRIDE == PAT_REG_BASE) begin
                pat_reg[int'(index) / REG_STRIDE] = data[PAT_W-1:0];
            end else begin
                rep_reg[int'(index) / REG_STRIDE] = data;
            end
        endfunction

        // pattern k must be in use, short enough and fully inside the window
        function bit head_matches(int k);
            int plen;
            plen = int'(pat_reg[k][LEN_W-1:0]);
            if (plen == 0 || plen > WINDOW_BYTES || plen > fill) return 1'b0;
            for (int i = 0; i < plen; i++) begin
                if (pat_reg[k][LEN_W + 8 * i +: 8] != window[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void drop_head(int n);
            for (int i = 0; i + n < fill; i++) window[i] = window[i + n];
            fill -= n;
        endfunction

        // first matching pattern in table order wins, else the head byte passes
        function void head_step();
            int rlen;
            for (int k = 0; k < MAX_PATTERNS; k++) begin
                if (head_matches(k)) begin
                    rlen = int'(rep_reg[k][LEN_W-1:0]);
                    if (rlen > MAX_REPLACEMENT) rlen = MAX_REPLACEMENT;
                    for (int i = 0; i < rlen; i++) begin
                        emitted.push_back(rep_reg[k][LEN_W + 8 * i +: 8]);
                    end
                    drop_head(int'(pat_reg[k][LEN_W-1:0]));
                    return;
                end
            end
            emitted.push_back(window[0]);
            drop_head(1);
        endfunction

        function void note_input(t_in item);
            t_out res;
            emitted.delete();
            if (fill >= WINDOW_BYTES) fill = WINDOW_BYTES - 1;
            window[fill] = item.in_byte;
            fill++;
            // chunk end flushes the whole window, a full window makes one step
            if (item.chunk_end) begin
                while (fill > 0) head_step();
            end else if (fill == WINDOW_BYTES) begin
                head_step();
            end
            // chunk that ends with nothing to show gets a bare marker
            if (item.chunk_end && emitted.size() == 0) begin
                res.out_byte   = 8'h00;
                res.byte_valid = 1'b0;
                res.chunk_done = 1'b1;
                res.run_last   = 1'b1;
                expected_q.push_back(res);
                return;
            end
            foreach (emitted[i]) begin
                res.out_byte   = emitted[i];
                res.byte_valid = 1'b1;
                res.run_last   = (i == emitted.size() - 1);
                res.chunk_done = item.chunk_end && res.run_last;
                expected_q.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("output %h with nothing pending", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid,
                                          want.byte_valid));
            if (got.chunk_done !== want.chunk_done)
                report_mismatch($sformatf("chunk_done %b, want %b", got.chunk_done,
                                          want.chunk_done));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        endtask
    endclass

    typedef enum {CFG_RANDOM, CFG_SHORT, CFG_ALL_ONES} t_cfg_mode;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 36;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    escaper_scoreboard sb;
    logic [7:0]        alphabet [4];
    int                calm_left = 0;
    t_cfg_mode         plan [5] = '{CFG_RANDOM, CFG_SHORT, CFG_ALL_ONES, CFG_RANDOM, CFG_SHORT};

    multi_pattern_byte_escaper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_IDX_W-1:0] pat_index(int k);
        return CFG_IDX_W'(PAT_REG_BASE + REG_STRIDE * k);
    endfunction

    function automatic logic [CFG_IDX_W-1:0] rep_index(int k);
        return CFG_IDX_W'(REP_REG_BASE + REG_STRIDE * k);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_entry(int len, logic [REP_DATA_W-1:0] bytes);
        return {bytes, LEN_W'(len)};
    endfunction

    // pattern bytes from the shared alphabet, junk above the pattern field
    function automatic logic [CFG_DATA_W-1:0] random_pattern(t_cfg_mode mode);
        logic [CFG_DATA_W-1:0] value;
        int                    len;
        int                    r;
        value = CFG_DATA_W'({$urandom, $urandom});
        r = $urandom_range(0, 19);
        if (mode == CFG_SHORT) len = $urandom_range(1, 2);
        else if (r < 3) len = 0;
        else if (r < 6) len = $urandom_range(5, 7);
        else len = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) value[LEN_W + 8 * i +: 8] = alphabet[$urandom_range(0, 3)];
        value[LEN_W-1:0] = LEN_W'(len);
        return value;
    endfunction

    // one input transaction, optional idle cycles ahead of it
    task automatic send_item(input logic [7:0] value, input logic last);
        t_in item;
        int  gap;
        item.in_byte = value;
        item.chunk_end = last;
        if (calm_left != 0) begin
            gap = 0;
            calm_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 30);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(item);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.store_reg(index, data);
    endtask

    // out-of-range index last, it must leave the table alone
    task automatic program_table(t_cfg_mode mode);
        for (int i = 0; i < 4; i++) begin
            alphabet[i] = ($urandom_range(0, 5) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        end
        for (int k = 0; k < NUM_PAIRS; k++) begin
            if (mode == CFG_ALL_ONES) begin
                cfg_write(pat_index(k), '1);
                cfg_write(rep_index(k), '1);
            end else begin
                cfg_write(pat_index(k), random_pattern(mode));
                cfg_write(rep_index(k), CFG_DATA_W'({$urandom, $urandom}));
            end
        end
        cfg_write(CFG_IDX_W'($urandom_range(CFG_REGS, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
    endtask

    // whole patterns, cut-off patterns and loose bytes
    task automatic run_random(int n_items);
        int sent;
        int k;
        int len;
        int cut;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            k = $urandom_range(0, NUM_PAIRS - 1);
            len = int'(sb.pat_reg[k][LEN_W-1:0]);
            if (r < 6 && len >= 1 && len <= 4) begin
                cut = (r == 5) ? $urandom_range(1, len) : len;
                for (int i = 0; i < cut; i++) begin
                    send_item(sb.pat_reg[k][LEN_W + 8 * i +: 8],
                              (i == cut - 1) && (r == 5 || $urandom_range(0, 3) == 0));
                end
                sent += cut;
            end else begin
                send_item(($urandom_range(0, 1) == 1) ? alphabet[$urandom_range(0, 3)]
                                                      : 8'($urandom),
                          $urandom_range(0, 5) == 0);
                sent++;
            end
        end
    endtask

    // let the sequencer finish steps that give no output
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: random back-pressure and result checking
    initial begin : out_side
        int hold;
        int gap;
        hold = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold != 0) begin
                hold--;
            end else if (i_out_ready) begin
                gap = pick_gap();
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    hold = gap - 1;
                end else begin
                    hold = $urandom_range(0, 8);
                end
            end else begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 12);
            end
        end
    end

    // main sequence
    initial begin
        sb = new();
        sb.clear();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset: every byte passes through
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h08, 1'b0);
        send_item(8'h10, 1'b1);
        wait_drained();

        // "ab" deleted, 0xff grows to seven bytes, "abcd" shadowed by "ab",
        // four zero bytes shrink to one
        cfg_write(pat_index(0), pack_entry(2, 56'h6261));
        cfg_write(rep_index(0), pack_entry(0, 56'hDEAD));
        cfg_write(pat_index(1), pack_entry(1, 56'hFF));
        cfg_write(rep_index(1), pack_entry(7, 56'h11_22_33_44_80_FF_00));
        cfg_write(pat_index(2), pack_entry(4, 56'h64636261));
        cfg_write(rep_index(2), pack_entry(3, 56'h777777));
        cfg_write(pat_index(3), pack_entry(4, 56'h0));
        cfg_write(rep_index(3), pack_entry(1, 56'h5A));
        cfg_write(CFG_IDX_W'(CFG_REGS), '1);
        i_cfg_valid <= 1'b0;

        // chunk reduced to nothing gives a bare marker
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
        // widest expansion on one chunk end
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // full-window match, then a pattern too long for the chunk rest
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h61, 1'b1);
        // table order and a step with empty output
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b0);
        send_item(8'h64, 1'b0);
        send_item(8'h65, 1'b1);
        wait_drained();

        foreach (plan[p]) begin
            program_table(plan[p]);
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

// File: files.f
design/mpbe_pkg.sv
design/multi_pattern_byte_escaper_top.sv
verif/tb.sv
